[rtl/mbgs_pkg.sv]
// shared constants, register indexes and types of the masked bilinear grid sampler
`default_nettype none

package mbgs_pkg;

	localparam int DEF_GRID_SIDE  = 20;
	localparam int DEF_COORD_FRAC = 8;

	localparam int DATA_W      = 24;
	localparam int INDEX_W     = 9;
	localparam int CFG_IDX_W   = 2;
	localparam int WEIGHT_FRAC = 16;
	localparam int WEIGHT_W    = WEIGHT_FRAC + 1;
	localparam int WEIGHT_ONE  = 1 << WEIGHT_FRAC;
	localparam int SUM_W       = DATA_W + WEIGHT_W + 1;
	localparam int DIV_W       = DATA_W;
	localparam int DIV_CNT_W   = $clog2(DIV_W + 1);

	localparam logic [CFG_IDX_W-1:0] REG_MIN_X  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_Y  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd3;

	localparam logic [DATA_W-1:0] RST_MIN  = 24'hFA33A0;
	localparam logic [DATA_W-1:0] RST_SIZE = 24'h0B98C0;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	typedef struct packed {
		logic                     valid;
		logic signed [DATA_W-1:0] height;
	} cell_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_CNT_W-1:0] count;
		logic [DIV_W-1:0]     rem_init;
		logic [DIV_W-1:0]     low;
		logic [DIV_W-1:0]     divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
	} div_rsp_t;

endpackage

`default_nettype wire

[rtl/mbgs_ifs.sv]
// valid/ready channel interfaces for commands and results
`default_nettype none

interface mbgs_in_if import mbgs_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     command;
	logic [INDEX_W-1:0]       cell_index;
	logic signed [DATA_W-1:0] cell_height;
	logic                     cell_valid;
	logic signed [DATA_W-1:0] pos_x;
	logic signed [DATA_W-1:0] pos_y;

	modport source (output valid, command, cell_index, cell_height, cell_valid, pos_x, pos_y,
		input ready);
	modport sink (input valid, command, cell_index, cell_height, cell_valid, pos_x, pos_y,
		output ready);
endinterface

interface mbgs_out_if import mbgs_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     found;
	logic signed [DATA_W-1:0] height;

	modport source (output valid, found, height, input ready);
	modport sink (input valid, found, height, output ready);
endinterface

`default_nettype wire

[rtl/mbgs_div.sv]
// shared restoring divider, one quotient bit per cycle
`default_nettype none

module mbgs_div import mbgs_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     low_q;
	logic [DIV_W-1:0]     quot_q;
	logic [DIV_W-1:0]     div_q;

	logic [DIV_W:0]   trial;
	logic             fits;
	logic [DIV_W-1:0] rem_nx;

	always_comb begin
		trial  = {rem_q, low_q[DIV_W-1]};
		fits   = trial >= {1'b0, div_q};
		rem_nx = fits ? DIV_W'(trial - {1'b0, div_q}) : trial[DIV_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == DIV_CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.count;
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.rem_init;
			low_q  <= req.low;
			div_q  <= req.divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= rem_nx;
			low_q  <= low_q << 1;
			quot_q <= {quot_q[DIV_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

`default_nettype wire

[rtl/mbgs_store.sv]
// grid cell memory with valid flags and a clearing sweep after reset
`default_nettype none

module mbgs_store import mbgs_pkg::*; #(
	parameter int GRID_SIDE = DEF_GRID_SIDE
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 we,
	input  wire logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0] waddr,
	input  wire cell_t                                wdata,
	input  wire logic                                 re,
	input  wire logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0] raddr,
	output cell_t                                     rdata,
	output logic                                      busy
);

	localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
	localparam int AW         = $clog2(CELL_COUNT);

	cell_t          mem [CELL_COUNT];
	cell_t          rdata_q;
	logic           clr_busy_q;
	logic [AW-1:0]  clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(CELL_COUNT - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
	assign busy  = clr_busy_q;

endmodule

`default_nettype wire

[rtl/masked_bilinear_grid_sampler.sv]
// top level: command sequencer, bilinear blend and result register
//
// Commands arrive on in_ch, one transfer each; every command gives exactly one
// transfer on out_ch. A write command (command 0) stores one cell's height and
// valid flag and answers found 0, height 0. A sample command (command 1) maps
// pos_x/pos_y into the grid, blends the up to four valid neighbor cells and
// answers the weighted mean height, or found 0. The shared divider produces
// Q = clog2(GRID_SIDE*2^F + 1) quotient bits for each grid coordinate and 24
// for the final mean, and the four corners are read one after another through
// the single memory read port. in_ch.ready is low while a command is in
// progress. The result sits in an output register; a new command is taken
// while it waits, and the sequencer holds in its last step until out_ch is
// free. After reset the cell memory is swept clear, one entry a cycle, across
// all GRID_SIDE*GRID_SIDE entries (400 by default) with in_ch.ready low.
// Bound registers are written through cfg_we/cfg_index/cfg_wdata; the user
// must write them only while idle, which the block itself does not enforce.
`default_nettype none

module masked_bilinear_grid_sampler import mbgs_pkg::*; #(
	parameter int GRID_SIDE           = DEF_GRID_SIDE,
	parameter int COORD_FRACTION_BITS = DEF_COORD_FRAC
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	mbgs_in_if.sink                   in_ch,
	mbgs_out_if.source                out_ch,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DATA_W-1:0]    cfg_wdata
);

	localparam int F          = COORD_FRACTION_BITS;
	localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
	localparam int AW         = $clog2(CELL_COUNT);
	localparam int CW         = $clog2(GRID_SIDE);
	localparam int SW         = $clog2(GRID_SIDE + 1);
	localparam int QC         = $clog2(GRID_SIDE * (1 << F) + 1);
	localparam int NUM_W      = DATA_W + SW + F;
	localparam int HALF       = 1 << (F - 1);
	localparam int S_TOP      = (GRID_SIDE - 1) << F;
	localparam int SXW        = $clog2(S_TOP + 1);

	typedef enum logic [11:0] {
		S_IDLE = 12'b000000000001,
		S_CHK  = 12'b000000000010,
		S_DX   = 12'b000000000100,
		S_WX   = 12'b000000001000,
		S_DY   = 12'b000000010000,
		S_WY   = 12'b000000100000,
		S_CORD = 12'b000001000000,
		S_RD   = 12'b000010000000,
		S_MAC  = 12'b000100000000,
		S_FIN  = 12'b001000000000,
		S_WF   = 12'b010000000000,
		S_DONE = 12'b100000000000
	} state_t;

	state_t state_q;

	logic [DATA_W-1:0] min_x_q, min_y_q, size_x_q, size_y_q;

	logic [DATA_W-1:0]  px_q, py_q;
	logic [DATA_W-1:0]  dx_q, dy_q;
	logic [SXW-1:0]     sx_q, sy_q;
	logic [CW-1:0]      c0_q, c1_q, r0_q, r1_q;
	logic [WEIGHT_W-1:0] wx0_q, wx1_q, wy0_q, wy1_q;
	logic [WEIGHT_W-1:0] w_q;
	logic [1:0]         k_q;
	logic [SUM_W-1:0]   sum_q;
	logic [WEIGHT_W-1:0] total_q;
	logic               neg_q;
	logic               res_found_q;
	logic [DATA_W-1:0]  res_height_q;
	logic               out_valid_q;
	logic               out_found_q;
	logic [DATA_W-1:0]  out_height_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic          store_busy;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	cell_t         mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	cell_t         mem_rdata;

	logic in_xfer;
	logic out_free;

	logic [DATA_W:0]   dx, dy;
	logic              x_out, y_out;
	logic [NUM_W-1:0]  num_x, num_y;
	logic signed [DIV_W+1:0] s_raw;
	logic [SXW-1:0]    s_clamp;
	logic [CW-1:0]     cx0, cy0;
	logic [WEIGHT_W-1:0] fx, fy;
	logic [WEIGHT_W-1:0] wy_sel, wx_sel;
	logic [CW-1:0]     r_sel, c_sel;
	logic [2*WEIGHT_W-1:0] wprod;
	logic [SUM_W-1:0]  prod;
	logic [SUM_W-1:0]  mag;

	assign in_xfer  = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;

	assign in_ch.ready   = (state_q == S_IDLE) && !store_busy;
	assign out_ch.valid  = out_valid_q;
	assign out_ch.found  = out_found_q;
	assign out_ch.height = out_height_q;

	// bounds check and coordinate numerators
	always_comb begin
		dx    = {px_q[DATA_W-1], px_q} - {min_x_q[DATA_W-1], min_x_q};
		dy    = {py_q[DATA_W-1], py_q} - {min_y_q[DATA_W-1], min_y_q};
		x_out = (size_x_q == '0) || dx[DATA_W] || (dx[DATA_W-1:0] > size_x_q);
		y_out = (size_y_q == '0) || dy[DATA_W] || (dy[DATA_W-1:0] > size_y_q);
		num_x = (NUM_W'(dx_q) * NUM_W'(GRID_SIDE)) << F;
		num_y = (NUM_W'(dy_q) * NUM_W'(GRID_SIDE)) << F;
	end

	// quotient minus half a cell, clamped into the grid
	always_comb begin
		s_raw = $signed({2'b00, div_rsp.quot}) - $signed((DIV_W + 2)'(HALF));
		if (s_raw < 0) begin
			s_clamp = '0;
		end else if (s_raw > $signed((DIV_W + 2)'(S_TOP))) begin
			s_clamp = SXW'(S_TOP);
		end else begin
			s_clamp = SXW'(s_raw);
		end
	end

	always_comb begin
		cx0 = CW'(sx_q >> F);
		cy0 = CW'(sy_q >> F);
		fx  = WEIGHT_W'(sx_q[F-1:0]) << (WEIGHT_FRAC - F);
		fy  = WEIGHT_W'(sy_q[F-1:0]) << (WEIGHT_FRAC - F);
	end

	// corner selection, weight and address
	always_comb begin
		wy_sel    = k_q[1] ? wy1_q : wy0_q;
		wx_sel    = k_q[0] ? wx1_q : wx0_q;
		r_sel     = k_q[1] ? r1_q : r0_q;
		c_sel     = k_q[0] ? c1_q : c0_q;
		wprod     = {{WEIGHT_W{1'b0}}, wy_sel} * {{WEIGHT_W{1'b0}}, wx_sel};
		mem_raddr = AW'(r_sel) * AW'(GRID_SIDE) + AW'(c_sel);
		mem_re    = (state_q == S_RD);
		prod      = {{(SUM_W - DATA_W){mem_rdata.height[DATA_W-1]}}, mem_rdata.height}
			* {{(SUM_W - WEIGHT_W){1'b0}}, w_q};
		mag       = sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;
	end

	always_comb begin
		mem_we          = in_xfer && (in_ch.command == CMD_WRITE)
			&& (32'(in_ch.cell_index) < 32'(CELL_COUNT));
		mem_waddr       = AW'(in_ch.cell_index);
		mem_wdata.valid = in_ch.cell_valid;
		mem_wdata.height = in_ch.cell_height;
	end

	always_comb begin
		div_req.start    = 1'b0;
		div_req.count    = DIV_CNT_W'(QC);
		div_req.rem_init = DIV_W'(num_x >> QC);
		div_req.low      = DIV_W'(num_x[QC-1:0]) << (DIV_W - QC);
		div_req.divisor  = size_x_q;
		case (state_q)
			S_DX: begin
				div_req.start = 1'b1;
			end
			S_DY: begin
				div_req.start    = 1'b1;
				div_req.rem_init = DIV_W'(num_y >> QC);
				div_req.low      = DIV_W'(num_y[QC-1:0]) << (DIV_W - QC);
				div_req.divisor  = size_y_q;
			end
			S_FIN: begin
				div_req.start    = (total_q != '0);
				div_req.count    = DIV_CNT_W'(DIV_W);
				div_req.rem_init = DIV_W'(mag >> DIV_W);
				div_req.low      = mag[DIV_W-1:0];
				div_req.divisor  = DIV_W'(total_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q  <= RST_MIN;
			min_y_q  <= RST_MIN;
			size_x_q <= RST_SIZE;
			size_y_q <= RST_SIZE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_X:  min_x_q  <= cfg_wdata;
				REG_MIN_Y:  min_y_q  <= cfg_wdata;
				REG_SIZE_X: size_x_q <= cfg_wdata;
				REG_SIZE_Y: size_y_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= (in_ch.command == CMD_SAMPLE) ? S_CHK : S_DONE;
					end
				end
				S_CHK:  state_q <= (x_out || y_out) ? S_DONE : S_DX;
				S_DX:   state_q <= S_WX;
				S_WX:   if (div_rsp.done) state_q <= S_DY;
				S_DY:   state_q <= S_WY;
				S_WY:   if (div_rsp.done) state_q <= S_CORD;
				S_CORD: begin
					k_q     <= '0;
					state_q <= S_RD;
				end
				S_RD:   state_q <= S_MAC;
				S_MAC: begin
					k_q     <= k_q + 2'd1;
					state_q <= (k_q == 2'd3) ? S_FIN : S_RD;
				end
				S_FIN:  state_q <= (total_q == '0) ? S_DONE : S_WF;
				S_WF:   if (div_rsp.done) state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				px_q         <= in_ch.pos_x;
				py_q         <= in_ch.pos_y;
				res_found_q  <= 1'b0;
				res_height_q <= '0;
			end
			S_CHK: begin
				dx_q <= dx[DATA_W-1:0];
				dy_q <= dy[DATA_W-1:0];
			end
			S_WX:   if (div_rsp.done) sx_q <= s_clamp;
			S_WY:   if (div_rsp.done) sy_q <= s_clamp;
			S_CORD: begin
				c0_q    <= cx0;
				r0_q    <= cy0;
				c1_q    <= (cx0 == CW'(GRID_SIDE - 1)) ? cx0 : cx0 + CW'(1);
				r1_q    <= (cy0 == CW'(GRID_SIDE - 1)) ? cy0 : cy0 + CW'(1);
				wx1_q   <= fx;
				wy1_q   <= fy;
				wx0_q   <= WEIGHT_W'(WEIGHT_ONE) - fx;
				wy0_q   <= WEIGHT_W'(WEIGHT_ONE) - fy;
				sum_q   <= '0;
				total_q <= '0;
			end
			S_RD:   w_q <= WEIGHT_W'(wprod >> WEIGHT_FRAC);
			S_MAC: begin
				// invalid cells and zero weights add nothing
				if (mem_rdata.valid) begin
					sum_q   <= sum_q + prod;
					total_q <= total_q + w_q;
				end
			end
			S_FIN:  neg_q <= sum_q[SUM_W-1];
			S_WF: begin
				if (div_rsp.done) begin
					res_found_q  <= 1'b1;
					res_height_q <= neg_q ? (~div_rsp.quot + DATA_W'(1)) : div_rsp.quot;
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_found_q  <= res_found_q;
					out_height_q <= res_height_q;
				end
			end
			default: begin
			end
		endcase
	end

	mbgs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	mbgs_store #(
		.GRID_SIDE (GRID_SIDE)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.re     (mem_re),
		.raddr  (mem_raddr),
		.rdata  (mem_rdata),
		.busy   (store_busy)
	);

	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		store_busy |-> !in_ch.ready)
		else $error("command taken during memory clear");

	a_div_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_WX || state_q == S_WY || state_q == S_WF))
		else $error("divider finished outside a wait step");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.found) |-> (out_ch.height == '0))
		else $error("not found result with nonzero height");

	a_done_to_output: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> (out_ch.valid && state_q == S_IDLE))
		else $error("finished command did not reach the output register");

endmodule

`default_nettype wire
